### rtl/ali_pkg.sv
`default_nettype none

package ali_pkg;

   // Number of entries the list can hold.
   localparam int unsigned CAPACITY = 128;

   // Width of the element count, which must be able to hold CAPACITY itself.
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   // Width of an index into the entry store.
   localparam int unsigned ADDR_W = $clog2(CAPACITY);

   // Field widths of the request and response beats.
   localparam int unsigned POS_W   = 8;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned LCNT_W  = 8;

   // Width used for comparing positions against the count, with room for count + 1.
   localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // Operation codes.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request fields
      logic commit;  // apply the captured operation and register its response
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_ok;   // the captured operation is legal
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/ali_datapath.sv
`default_nettype none

module ali_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ali_pkg::dp_cmd_type                  cmd,
   output ali_pkg::dp_status_type                    status,
   input  wire logic                                 req_kind,
   input  wire logic [ali_pkg::POS_W-1:0]            req_position,
   input  wire logic signed [ali_pkg::VALUE_W-1:0]   req_value,
   output logic                                      rsp_ok,
   output logic signed [ali_pkg::VALUE_W-1:0]        rsp_removed_value,
   output logic [ali_pkg::LCNT_W-1:0]                rsp_list_count
);

   logic                                   kind_ff;
   logic [ali_pkg::POS_W-1:0]              pos_ff;
   logic signed [ali_pkg::VALUE_W-1:0]     value_ff;
   logic [ali_pkg::CNT_W-1:0]              count_ff;
   logic [ali_pkg::CNT_W-1:0]              count_in;
   logic signed [ali_pkg::VALUE_W-1:0]     entries_ff [ali_pkg::CAPACITY];

   logic                                   rsp_ok_ff;
   logic signed [ali_pkg::VALUE_W-1:0]     rsp_removed_ff;
   logic [ali_pkg::LCNT_W-1:0]             rsp_count_ff;

   logic [ali_pkg::CMP_W-1:0]              pos_ext;
   logic [ali_pkg::CMP_W-1:0]              pos_m1;
   logic [ali_pkg::CMP_W-1:0]              cnt_ext;
   logic                                   op_ok;
   logic                                   do_insert;
   logic                                   do_delete;
   logic signed [ali_pkg::VALUE_W-1:0]     taken;

   assign pos_ext = ali_pkg::CMP_W'(pos_ff);
   assign pos_m1  = pos_ext - ali_pkg::CMP_W'(1);
   assign cnt_ext = ali_pkg::CMP_W'(count_ff);

   always_comb begin
      if (kind_ff == ali_pkg::KIND_INSERT) begin
         op_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + ali_pkg::CMP_W'(1)) &&
                 (cnt_ext < ali_pkg::CMP_W'(ali_pkg::CAPACITY));
      end else begin
         op_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
      end
   end

   assign status.op_ok = op_ok;
   assign do_insert    = cmd.commit && op_ok && (kind_ff == ali_pkg::KIND_INSERT);
   assign do_delete    = cmd.commit && op_ok && (kind_ff == ali_pkg::KIND_DELETE);

   // The entry being removed; only meaningful when the delete is legal.
   assign taken = entries_ff[pos_m1[ali_pkg::ADDR_W-1:0]];

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + ali_pkg::CNT_W'(1);
      end else if (do_delete) begin
         count_in = count_ff - ali_pkg::CNT_W'(1);
      end
   end

   // Each entry looks only at its neighbours, so all entries shift together on the same clock edge.
   for (genvar i = 0; i < ali_pkg::CAPACITY; i++) begin : g_entry
      localparam logic [ali_pkg::CMP_W-1:0] IDX = ali_pkg::CMP_W'(i);
      logic signed [ali_pkg::VALUE_W-1:0] entry_in;

      always_comb begin
         entry_in = entries_ff[i];
         if (do_insert) begin
            if (IDX == pos_m1) begin
               entry_in = value_ff;
            end else if (IDX > pos_m1) begin
               if (i > 0) begin
                  entry_in = entries_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end else if (do_delete) begin
            if ((IDX >= pos_m1) && (i < ali_pkg::CAPACITY - 1)) begin
               entry_in = entries_ff[(i < ali_pkg::CAPACITY - 1) ? i + 1 : i];
            end
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (cmd.load) begin
         kind_ff  <= req_kind;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (cmd.commit) begin
         rsp_ok_ff      <= op_ok;
         rsp_removed_ff <= do_delete ? taken : '0;
         rsp_count_ff   <= ali_pkg::LCNT_W'(count_in);
      end
   end

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_list_count    = rsp_count_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      ali_pkg::CMP_W'(count_ff) <= ali_pkg::CMP_W'(ali_pkg::CAPACITY))
      else $error("list count above capacity");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !op_ok) |=> (count_ff == $past(count_ff)))
      else $error("rejected operation changed the count");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_in)) && (count_ff != '0))
      else $error("insert did not grow the list");

   a_insert_no_removed: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (kind_ff == ali_pkg::KIND_INSERT)) |=> (rsp_removed_ff == '0))
      else $error("insert reported a removed value");

endmodule

`default_nettype wire

### rtl/ali_controller.sv
`default_nettype none

module ali_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output logic                    rsp_valid,
   output ali_pkg::dp_cmd_type     cmd,
   input  wire ali_pkg::dp_status_type status
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign busy       = (state_ff == ST_EXEC);
   assign cmd.load   = start && (state_ff == ST_IDLE);
   assign cmd.commit = (state_ff == ST_EXEC);
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               // The outcome, legal or not, always yields one response beat.
               rsp_valid_ff <= 1'b1 | status.op_ok;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/array_list_insert_delete_core.sv
// A response beat is registered at the end of the execute state, which follows the capture of the request beat.
// A new request is taken only in the idle state; busy is high in the execute cycle.
// The whole list shifts by one place at once through a row of entry registers that all update on the same edge.
// Reset is synchronous and active high; it empties the list and idles the controller.
// Response beats last exactly one cycle under rsp_valid; the receiver cannot stall them.
`default_nettype none

module array_list_insert_delete_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_kind,
   input  wire logic [ali_pkg::POS_W-1:0]            req_position,
   input  wire logic signed [ali_pkg::VALUE_W-1:0]   req_value,
   output logic                                      rsp_valid,
   output logic                                      rsp_ok,
   output logic signed [ali_pkg::VALUE_W-1:0]        rsp_removed_value,
   output logic [ali_pkg::LCNT_W-1:0]                rsp_list_count
);

   // The controller sequences each request beat through a capture cycle and an
   // execute cycle. The datapath holds the captured request, the entry row and the
   // count, decides whether the operation is legal, and registers the response.
   ali_pkg::dp_cmd_type    cmd;
   ali_pkg::dp_status_type status;

   ali_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // A rejected operation leaves the entries and the count untouched; the response
   // then carries a cleared flag, a zero removed value and the unchanged count.
   ali_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_ok            (rsp_ok),
      .rsp_removed_value (rsp_removed_value),
      .rsp_list_count    (rsp_list_count)
   );

endmodule

`default_nettype wire
